FILE: src/ccross_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccross_pkg;

   // grid and number format
   localparam int MAX_CELLS_PER_SIDE = 64;
   localparam int FRAC_BITS          = 16;
   localparam int AXES               = 3;

   // field widths
   localparam int TAG_W      = 16;
   localparam int POS_W      = 32;
   localparam int CELL_W     = 18;
   localparam int TIME_W     = 32;
   localparam int CPS_W      = 7;
   localparam int CSZ_W      = 31;
   localparam int LEN_W      = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   // derived internal widths
   localparam int COORD_W = $clog2(MAX_CELLS_PER_SIDE);
   localparam int NCL_W   = $clog2(MAX_CELLS_PER_SIDE + 1);
   localparam int N2_W    = $clog2(MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE + 1);
   localparam int N3_W    = $clog2(MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE
                                   * MAX_CELLS_PER_SIDE + 1);
   localparam int MODD_W  = POS_W + 1;
   localparam int MODS_W  = LEN_W + 1;
   localparam int LOC_W   = LEN_W + 2;
   localparam int PROD_W  = NCL_W + CSZ_W;
   localparam int DIST_W  = PROD_W + 2;
   localparam int MAG_W   = DIST_W - 1;
   localparam int TDVD_W  = MAG_W + FRAC_BITS - 1;
   localparam int VMAG_W  = POS_W;
   localparam int CQ_W    = CELL_W + NCL_W;
   localparam int KEY_W   = TDVD_W + 1;

   localparam int FIFO_DEPTH = 4;

   // register reset values
   localparam logic [CPS_W-1:0] CPS_RESET = CPS_W'(8);
   localparam logic [CSZ_W-1:0] CSZ_RESET = CSZ_W'(65536);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(524288);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELLS_PER_SIDE = 2'd0,
      CSR_CELL_SIZE      = 2'd1,
      CSR_BOX_LENGTH     = 2'd2
   } csr_index_type;

   // cleaned up configuration seen by the datapath
   typedef struct packed {
      logic [NCL_W-1:0] n;
      logic [N2_W-1:0]  n2;
      logic [N3_W-1:0]  n3;
      logic [CSZ_W-1:0] csz;
      logic [LEN_W-1:0] len;
   } ccross_cfg_type;

   typedef struct packed {
      logic              vneg;
      logic              vzero;
      logic              xneg;
      logic [VMAG_W-1:0] av;
   } ccross_axis_type;

   // classified item queued between front and back
   typedef struct packed {
      logic [TAG_W-1:0]                tag;
      logic [CELL_W-1:0]               cell_idx;
      logic [AXES-1:0][MODD_W-1:0]     xmag;
      ccross_axis_type [AXES-1:0]      axis;
   } ccross_item_type;

   typedef struct packed {
      logic [TAG_W-1:0]           tag;
      ccross_axis_type [AXES-1:0] axis;
   } ccross_ph1_type;

   typedef struct packed {
      logic [TAG_W-1:0]               tag;
      logic [AXES-1:0][COORD_W-1:0]   coord;
      logic [AXES-1:0]                vneg;
      logic [AXES-1:0]                vzero;
   } ccross_ph2_type;

endpackage

`default_nettype wire

FILE: src/ccross_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ccross_div
   import ccross_pkg::*;
#(
   parameter int W  = 33,
   parameter int DW = 32
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [W-1:0]  dividend,
   input  wire logic [DW-1:0] divisor,
   output logic [W-1:0]       quotient,
   output logic [DW-1:0]      remainder
);

   logic [DW-1:0] rem_ff [W];
   logic [W-1:0]  quo_ff [W];
   logic [W-1:0]  dvd_ff [W];
   logic [DW-1:0] dvs_ff [W];

   // one restoring step per stage, most significant dividend bit first
   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [DW-1:0] prev_rem;
      logic [W-1:0]  prev_quo;
      logic [W-1:0]  prev_dvd;
      logic [DW-1:0] prev_dvs;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [W-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign prev_rem = '0;
         assign prev_quo = '0;
         assign prev_dvd = dividend;
         assign prev_dvs = divisor;
      end else begin : g_next
         assign prev_rem = rem_ff[k-1];
         assign prev_quo = quo_ff[k-1];
         assign prev_dvd = dvd_ff[k-1];
         assign prev_dvs = dvs_ff[k-1];
      end

      assign trial  = {prev_rem, prev_dvd[W-1-k]};
      assign diff   = trial - {1'b0, prev_dvs};
      assign ge     = (trial >= {1'b0, prev_dvs});
      assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];

      always_comb begin
         quo_in          = prev_quo;
         quo_in[W-1-k]   = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            dvd_ff[k] <= prev_dvd;
            dvs_ff[k] <= prev_dvs;
         end
      end
   end

   assign quotient  = quo_ff[W-1];
   assign remainder = rem_ff[W-1];

endmodule

`default_nettype wire

FILE: src/ccross_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ccross_front
   import ccross_pkg::*;
(
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [TAG_W-1:0]        req_particle_tag,
   input  wire logic signed [POS_W-1:0] req_pos_x,
   input  wire logic signed [POS_W-1:0] req_pos_y,
   input  wire logic signed [POS_W-1:0] req_pos_z,
   input  wire logic signed [POS_W-1:0] req_vel_x,
   input  wire logic signed [POS_W-1:0] req_vel_y,
   input  wire logic signed [POS_W-1:0] req_vel_z,
   input  wire logic [CELL_W-1:0]       req_current_cell,
   input  wire ccross_cfg_type          cfg,
   input  wire logic                    fifo_full,
   output logic                         push,
   output ccross_item_type              push_item
);

   logic [AXES-1:0][POS_W-1:0] pos;
   logic [AXES-1:0][POS_W-1:0] vel;

   assign pos = {req_pos_z, req_pos_y, req_pos_x};
   assign vel = {req_vel_z, req_vel_y, req_vel_x};

   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;

   // classify each axis: doubled position offset by the half box, velocity sign and size
   always_comb begin
      logic [MODD_W:0] x;
      push_item.tag      = req_particle_tag;
      push_item.cell_idx = req_current_cell;
      for (int i = 0; i < AXES; i++) begin
         x = {pos[i][POS_W-1], pos[i], 1'b0} + {3'b000, cfg.len};
         push_item.axis[i].xneg  = x[MODD_W];
         push_item.xmag[i]       = x[MODD_W] ? MODD_W'(-x) : x[MODD_W-1:0];
         push_item.axis[i].vneg  = vel[i][POS_W-1];
         push_item.axis[i].vzero = (vel[i] == '0);
         push_item.axis[i].av    = vel[i][POS_W-1] ? -vel[i] : vel[i];
      end
   end

endmodule

`default_nettype wire

FILE: src/ccross_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ccross_fifo
   import ccross_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire ccross_item_type push_item,
   output logic                 full,
   input  wire logic            pop,
   output logic                 head_valid,
   output ccross_item_type      head_item
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   ccross_item_type   entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_in;

   assign full       = (count_ff == CNT_W'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow push");
`endif

endmodule

`default_nettype wire

FILE: src/ccross_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ccross_back
   import ccross_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ccross_cfg_type    cfg,
   input  wire logic              head_valid,
   input  wire ccross_item_type   head_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [TAG_W-1:0]       rsp_result_tag,
   output logic [TIME_W-1:0]      rsp_crossing_time,
   output logic [CELL_W-1:0]      rsp_next_cell,
   output logic                   rsp_never_crosses
);

   localparam int W1 = MODD_W;
   localparam int W2 = TDVD_W;

   logic adv;

   // whole pipeline moves when the output register is free or being taken
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && head_valid;

   // ---------------- phase one: position wrap and cell split ----------------
   logic [MODS_W-1:0] box2;
   assign box2 = {cfg.len, 1'b0};

   logic [MODD_W-1:0] pq [AXES];
   logic [MODS_W-1:0] pr [AXES];

   for (genvar i = 0; i < AXES; i++) begin : g_wrap
      ccross_div #(.W(MODD_W), .DW(MODS_W)) u_div (
         .clock     (clock),
         .en        (adv),
         .dividend  (head_item.xmag[i]),
         .divisor   (box2),
         .quotient  (pq[i]),
         .remainder (pr[i])
      );
   end

   logic [N3_W-1:0]   cdiv [AXES];
   logic [MODD_W-1:0] cq   [AXES];
   logic [N3_W-1:0]   cr   [AXES];

   assign cdiv[0] = N3_W'(cfg.n);
   assign cdiv[1] = N3_W'(cfg.n2);
   assign cdiv[2] = cfg.n3;

   for (genvar i = 0; i < AXES; i++) begin : g_cell
      ccross_div #(.W(MODD_W), .DW(N3_W)) u_div (
         .clock     (clock),
         .en        (adv),
         .dividend  (MODD_W'(head_item.cell_idx)),
         .divisor   (cdiv[i]),
         .quotient  (cq[i]),
         .remainder (cr[i])
      );
   end

   logic           v1_ff [W1];
   ccross_ph1_type s1_ff [W1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < W1; k++) begin
            v1_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff[0] <= head_valid;
         for (int k = 1; k < W1; k++) begin
            v1_ff[k] <= v1_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff[0] <= {head_item.tag, head_item.axis};
         for (int k = 1; k < W1; k++) begin
            s1_ff[k] <= s1_ff[k-1];
         end
      end
   end

   // ---------------- stage p1: coordinates and wrapped location ----------------
   logic                                p1_valid_ff;
   ccross_ph1_type                      p1_side_ff;
   logic [AXES-1:0][COORD_W-1:0]        p1_coord_ff;
   logic [AXES-1:0][COORD_W-1:0]        p1_coord_in;
   logic signed [LOC_W-1:0]             p1_loc_ff [AXES];
   logic signed [LOC_W-1:0]             p1_loc_in [AXES];

   always_comb begin
      logic [CQ_W-1:0]   c1_full;
      logic [CQ_W-1:0]   c0_full;
      logic [MODS_W-1:0] d;
      c1_full = CQ_W'(cq[0][CELL_W-1:0]) - CQ_W'(cq[1][CELL_W-1:0]) * CQ_W'(cfg.n);
      c0_full = CQ_W'(cq[1][CELL_W-1:0]) - CQ_W'(cq[2][CELL_W-1:0]) * CQ_W'(cfg.n);
      p1_coord_in[2] = cr[0][COORD_W-1:0];
      p1_coord_in[1] = c1_full[COORD_W-1:0];
      p1_coord_in[0] = c0_full[COORD_W-1:0];
      for (int i = 0; i < AXES; i++) begin
         d = (s1_ff[W1-1].axis[i].xneg && pr[i] != '0) ? box2 - pr[i] : pr[i];
         p1_loc_in[i] = $signed({1'b0, d}) - $signed({2'b00, cfg.len});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= v1_ff[W1-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_side_ff  <= s1_ff[W1-1];
         p1_coord_ff <= p1_coord_in;
         for (int i = 0; i < AXES; i++) begin
            p1_loc_ff[i] <= p1_loc_in[i];
         end
      end
   end

   // ---------------- stage p2: wall position product ----------------
   logic                         p2_valid_ff;
   ccross_ph1_type               p2_side_ff;
   logic [AXES-1:0][COORD_W-1:0] p2_coord_ff;
   logic signed [LOC_W-1:0]      p2_loc_ff  [AXES];
   logic [PROD_W-1:0]            p2_prod_ff [AXES];
   logic [PROD_W-1:0]            p2_prod_in [AXES];

   always_comb begin
      logic [NCL_W-1:0] wall;
      for (int i = 0; i < AXES; i++) begin
         wall = p1_side_ff.axis[i].vneg ? NCL_W'(p1_coord_ff[i])
                                        : NCL_W'(p1_coord_ff[i]) + 1'b1;
         p2_prod_in[i] = PROD_W'(wall) * PROD_W'(cfg.csz);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_side_ff  <= p1_side_ff;
         p2_coord_ff <= p1_coord_ff;
         for (int i = 0; i < AXES; i++) begin
            p2_loc_ff[i]  <= p1_loc_ff[i];
            p2_prod_ff[i] <= p2_prod_in[i];
         end
      end
   end

   // ---------------- stage p3: distance to the wall, in half units ----------------
   logic                         p3_valid_ff;
   ccross_ph1_type               p3_side_ff;
   logic [AXES-1:0][COORD_W-1:0] p3_coord_ff;
   logic [MAG_W-1:0]             p3_mag_ff [AXES];
   logic [MAG_W-1:0]             p3_mag_in [AXES];

   always_comb begin
      logic signed [DIST_W-1:0] span;
      for (int i = 0; i < AXES; i++) begin
         span = $signed({1'b0, p2_prod_ff[i], 1'b0})
              - $signed({{(DIST_W-LEN_W){1'b0}}, cfg.len})
              - DIST_W'(p2_loc_ff[i]);
         p3_mag_in[i] = span[DIST_W-1] ? MAG_W'(-span) : span[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_side_ff  <= p2_side_ff;
         p3_coord_ff <= p2_coord_ff;
         for (int i = 0; i < AXES; i++) begin
            p3_mag_ff[i] <= p3_mag_in[i];
         end
      end
   end

   // ---------------- phase two: time = distance / speed ----------------
   logic [TDVD_W-1:0] tq [AXES];
   logic [VMAG_W-1:0] tr [AXES];

   for (genvar i = 0; i < AXES; i++) begin : g_time
      ccross_div #(.W(TDVD_W), .DW(VMAG_W)) u_div (
         .clock     (clock),
         .en        (adv),
         .dividend  ({p3_mag_ff[i], {(FRAC_BITS-1){1'b0}}}),
         .divisor   (p3_side_ff.axis[i].av),
         .quotient  (tq[i]),
         .remainder (tr[i])
      );
   end

   logic           v2_ff [W2];
   ccross_ph2_type s2_ff [W2];
   ccross_ph2_type s2_head;

   always_comb begin
      s2_head.tag   = p3_side_ff.tag;
      s2_head.coord = p3_coord_ff;
      for (int i = 0; i < AXES; i++) begin
         s2_head.vneg[i]  = p3_side_ff.axis[i].vneg;
         s2_head.vzero[i] = p3_side_ff.axis[i].vzero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < W2; k++) begin
            v2_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v2_ff[0] <= p3_valid_ff;
         for (int k = 1; k < W2; k++) begin
            v2_ff[k] <= v2_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff[0] <= s2_head;
         for (int k = 1; k < W2; k++) begin
            s2_ff[k] <= s2_ff[k-1];
         end
      end
   end

   // ---------------- stage p4: least time and stepped coordinates ----------------
   logic                         p4_valid_ff;
   logic [TAG_W-1:0]             p4_tag_ff;
   logic [KEY_W-1:0]             p4_key_ff;
   logic [KEY_W-1:0]             p4_key_in;
   logic [AXES-1:0][COORD_W-1:0] p4_coord_ff;
   logic [AXES-1:0][COORD_W-1:0] p4_coord_in;

   always_comb begin
      logic [KEY_W-1:0]   key [AXES];
      logic [KEY_W-1:0]   m01;
      logic [COORD_W-1:0] c;
      logic [NCL_W-1:0]   top;
      ccross_ph2_type     s;
      s   = s2_ff[W2-1];
      top = cfg.n - 1'b1;
      for (int i = 0; i < AXES; i++) begin
         key[i] = {s.vzero[i], tq[i]};
      end
      m01       = (key[1] < key[0]) ? key[1] : key[0];
      p4_key_in = (key[2] < m01) ? key[2] : m01;
      for (int i = 0; i < AXES; i++) begin
         c              = s.coord[i];
         p4_coord_in[i] = c;
         if (key[i] == p4_key_in && !s.vzero[i]) begin
            if (s.vneg[i]) begin
               p4_coord_in[i] = (c == '0) ? top[COORD_W-1:0] : c - 1'b1;
            end else begin
               p4_coord_in[i] = (NCL_W'(c) == top) ? '0 : c + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (adv) begin
         p4_valid_ff <= v2_ff[W2-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_tag_ff   <= s2_ff[W2-1].tag;
         p4_key_ff   <= p4_key_in;
         p4_coord_ff <= p4_coord_in;
      end
   end

   // ---------------- output register: linear cell and saturated time ----------------
   logic [TAG_W-1:0]  rsp_tag_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic              rsp_never_ff;
   logic [TIME_W-1:0] time_in;
   logic [CELL_W-1:0] cell_in;

   always_comb begin
      logic [N3_W-1:0] lin;
      lin = N3_W'(p4_coord_ff[0]) * N3_W'(cfg.n2)
          + N3_W'(p4_coord_ff[1]) * N3_W'(cfg.n)
          + N3_W'(p4_coord_ff[2]);
      cell_in = lin[CELL_W-1:0];
      if (p4_key_ff[KEY_W-1] || p4_key_ff[TDVD_W-1:TIME_W] != '0) begin
         time_in = '1;
      end else begin
         time_in = p4_key_ff[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tag_ff   <= p4_tag_ff;
         rsp_time_ff  <= time_in;
         rsp_cell_ff  <= cell_in;
         rsp_never_ff <= p4_key_ff[KEY_W-1];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_tag    = rsp_tag_ff;
   assign rsp_crossing_time = rsp_time_ff;
   assign rsp_next_cell     = rsp_cell_ff;
   assign rsp_never_crosses = rsp_never_ff;

endmodule

`default_nettype wire

FILE: src/cell_crossing_time_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Cell boundary crossing time for a cubic periodic box cut into n x n x n cells.
// Each item carries a particle's tag, Q16.16 position and velocity and its linear
// cell index; the result gives the earliest wall crossing time (Q16.16, saturated,
// all ones with never_crosses set when the particle is at rest) and the cell it
// enters next, stepping every tied axis with periodic wrap. One item is accepted
// and one result delivered per clock cycle in steady state while the result side
// does not stall. The datapath holds two chains of pipelined restoring dividers:
// 33 stages for the box wrap and cell split, then 54 stages for the distance over
// speed division. A four-entry queue behind the input absorbs result-side stalls.
// Configuration writes are always accepted (csr_ready is tied high) and must only
// be issued while no item is in flight.
module cell_crossing_time_top
   import ccross_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [TAG_W-1:0]        req_particle_tag,
   input  wire logic signed [POS_W-1:0] req_pos_x,
   input  wire logic signed [POS_W-1:0] req_pos_y,
   input  wire logic signed [POS_W-1:0] req_pos_z,
   input  wire logic signed [POS_W-1:0] req_vel_x,
   input  wire logic signed [POS_W-1:0] req_vel_y,
   input  wire logic signed [POS_W-1:0] req_vel_z,
   input  wire logic [CELL_W-1:0]       req_current_cell,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [TAG_W-1:0]             rsp_result_tag,
   output logic [TIME_W-1:0]            rsp_crossing_time,
   output logic [CELL_W-1:0]            rsp_next_cell,
   output logic                         rsp_never_crosses,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   logic [CPS_W-1:0] cps_ff;
   logic [CSZ_W-1:0] csz_ff;
   logic [LEN_W-1:0] len_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cps_ff <= CPS_RESET;
         csz_ff <= CSZ_RESET;
         len_ff <= LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CELLS_PER_SIDE: cps_ff <= csr_data[CPS_W-1:0];
            CSR_CELL_SIZE:      csz_ff <= csr_data[CSZ_W-1:0];
            CSR_BOX_LENGTH:     len_ff <= csr_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamp grid size and box length, derive n squared and cubed
   ccross_cfg_type cfg;

   always_comb begin
      if (cps_ff == '0) begin
         cfg.n = NCL_W'(1);
      end else if (NCL_W'(cps_ff) > NCL_W'(MAX_CELLS_PER_SIDE)) begin
         cfg.n = NCL_W'(MAX_CELLS_PER_SIDE);
      end else begin
         cfg.n = NCL_W'(cps_ff);
      end
      cfg.n2  = N2_W'(cfg.n) * N2_W'(cfg.n);
      cfg.n3  = N3_W'(cfg.n2) * N3_W'(cfg.n);
      cfg.csz = csz_ff;
      cfg.len = (len_ff == '0) ? LEN_W'(1) : len_ff;
   end

   logic            fifo_full;
   logic            push;
   ccross_item_type push_item;
   logic            pop;
   logic            head_valid;
   ccross_item_type head_item;

   ccross_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_particle_tag (req_particle_tag),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_vel_x        (req_vel_x),
      .req_vel_y        (req_vel_y),
      .req_vel_z        (req_vel_z),
      .req_current_cell (req_current_cell),
      .cfg              (cfg),
      .fifo_full        (fifo_full),
      .push             (push),
      .push_item        (push_item)
   );

   ccross_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ccross_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_tag    (rsp_result_tag),
      .rsp_crossing_time (rsp_crossing_time),
      .rsp_next_cell     (rsp_next_cell),
      .rsp_never_crosses (rsp_never_crosses)
   );

endmodule

`default_nettype wire

FILE: test/cell_crossing_time_top_tb.sv
`timescale 1ns / 1ps

module cell_crossing_time_top_tb;
   import ccross_pkg::*;

   localparam longint NEVER = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int DRAIN_CYCLES = 150;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic [TAG_W-1:0]        tag;
      logic signed [POS_W-1:0] pos [3];
      logic signed [POS_W-1:0] vel [3];
      logic [CELL_W-1:0]       cell_idx;
   } particle_type;

   typedef struct {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] ctime;
      logic [CELL_W-1:0] next;
      logic              never;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [TAG_W-1:0] req_particle_tag = '0;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [POS_W-1:0] req_vel_x = '0, req_vel_y = '0, req_vel_z = '0;
   logic [CELL_W-1:0] req_current_cell = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [TAG_W-1:0] rsp_result_tag;
   logic [TIME_W-1:0] rsp_crossing_time;
   logic [CELL_W-1:0] rsp_next_cell;
   logic rsp_never_crosses;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_CELLS_PER_SIDE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // copy of the configuration registers
   logic [CPS_W-1:0] grid_cells = CPS_RESET;
   logic [CSZ_W-1:0] grid_cell_size = CSZ_RESET;
   logic [LEN_W-1:0] grid_box = LEN_RESET;

   crossing_type pending_crossings [$];
   int errors = 0;
   int quiet_cycles = 0;
   bit no_idle = 1'b0;
   int stall_left = 0;

   cell_crossing_time_top dut (.*);

   always #6 clock = ~clock;

   // time to reach the wall ahead along one axis, unsaturated
   function automatic longint unsigned wall_time(logic signed [POS_W-1:0] p,
         logic signed [POS_W-1:0] v, longint coord, longint len, longint csz);
      longint r, m, d, loc2, bound2, dist2;
      longint unsigned mag, av;
      if (v == 0) return NEVER;
      r = p;
      m = 2 * len;
      d = (2 * r + len) % m;
      if (d < 0) d += m;
      loc2 = d - len;
      if (v < 0) bound2 = 2 * coord * csz - len;
      else bound2 = 2 * (coord + 1) * csz - len;
      dist2 = bound2 - loc2;
      mag = (dist2 < 0) ? -dist2 : dist2;
      av = (v < 0) ? -longint'(v) : longint'(v);
      return (mag << (FRAC_BITS - 1)) / av;
   endfunction

   function automatic crossing_type predict_crossing(particle_type it);
      longint unsigned n, n2, id, tmin;
      longint unsigned cx [3];
      longint unsigned t [3];
      longint len;
      crossing_type res;
      n = (grid_cells == 0) ? 1 : (grid_cells > MAX_CELLS_PER_SIDE) ?
          MAX_CELLS_PER_SIDE : grid_cells;
      len = (grid_box == 0) ? 1 : grid_box;
      n2 = n * n;
      id = it.cell_idx;
      cx[0] = (id / n2) % n;
      cx[1] = (id % n2) / n;
      cx[2] = id % n;
      for (int i = 0; i < 3; i++)
         t[i] = wall_time(it.pos[i], it.vel[i], cx[i], len, grid_cell_size);
      tmin = t[0];
      if (t[1] < tmin) tmin = t[1];
      if (t[2] < tmin) tmin = t[2];
      // every tied axis steps
      for (int i = 0; i < 3; i++) begin
         if (t[i] == tmin && t[i] != NEVER) begin
            if (it.vel[i] < 0) cx[i] = (cx[i] + n - 1) % n;
            else cx[i] = (cx[i] + 1) % n;
         end
      end
      res.tag = it.tag;
      res.ctime = (tmin > 64'hFFFF_FFFF) ? '1 : tmin[TIME_W-1:0];
      res.next = CELL_W'(cx[0] * n2 + cx[1] * n + cx[2]);
      res.never = (tmin == NEVER);
      return res;
   endfunction

   // record expectations on accepted items, check results, watchdog
   always @(posedge clock) begin
      particle_type it;
      crossing_type exp_res;
      bit moved;
      moved = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         it.tag = req_particle_tag;
         it.pos[0] = req_pos_x; it.pos[1] = req_pos_y; it.pos[2] = req_pos_z;
         it.vel[0] = req_vel_x; it.vel[1] = req_vel_y; it.vel[2] = req_vel_z;
         it.cell_idx = req_current_cell;
         pending_crossings = {pending_crossings, predict_crossing(it)};
         moved = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         moved = 1'b1;
         if (pending_crossings.size() == 0) begin
            $error("result with no item pending, tag %0h", rsp_result_tag);
            errors++;
         end else begin
            exp_res = pending_crossings.pop_front();
            if (rsp_result_tag !== exp_res.tag) begin
               $error("result_tag expected %0h got %0h", exp_res.tag, rsp_result_tag);
               errors++;
            end
            if (rsp_crossing_time !== exp_res.ctime) begin
               $error("crossing_time expected %0h got %0h", exp_res.ctime,
                      rsp_crossing_time);
               errors++;
            end
            if (rsp_next_cell !== exp_res.next) begin
               $error("next_cell expected %0d got %0d", exp_res.next, rsp_next_cell);
               errors++;
            end
            if (rsp_never_crosses !== exp_res.never) begin
               $error("never_crosses expected %0b got %0b", exp_res.never,
                      rsp_never_crosses);
               errors++;
            end
         end
      end
      if (csr_valid && csr_ready) moved = 1'b1;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result-side stall bursts
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         rsp_stall = ($urandom_range(0, 2) == 0);
         stall_left = $urandom_range(0, 13);
      end
   end

   task automatic send_item(particle_type it);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_particle_tag = it.tag;
      req_pos_x = it.pos[0]; req_pos_y = it.pos[1]; req_pos_z = it.pos[2];
      req_vel_x = it.vel[0]; req_vel_y = it.vel[1]; req_vel_z = it.vel[2];
      req_current_cell = it.cell_idx;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_crossings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CELLS_PER_SIDE: grid_cells = value[CPS_W-1:0];
         CSR_CELL_SIZE:      grid_cell_size = value[CSZ_W-1:0];
         default:            grid_box = value[LEN_W-1:0];
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_grid(int cps, int csz, int len);
      drain();
      write_reg(CSR_CELLS_PER_SIDE, CSR_DATA_W'(cps));
      write_reg(CSR_CELL_SIZE, CSR_DATA_W'(csz));
      write_reg(CSR_BOX_LENGTH, CSR_DATA_W'(len));
   endtask

   function automatic logic signed [POS_W-1:0] rand_speed();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         2:       return 32'sh8000_0000;
         3:       return 32'sh7FFF_FFFF;
         4, 5, 6: return $urandom_range(0, 1) ? $urandom_range(1, 32'h4_0000)
                                              : -$urandom_range(1, 32'h4_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic particle_type rand_particle();
      particle_type it;
      longint len, n;
      len = (grid_box == 0) ? 1 : grid_box;
      n = (grid_cells == 0) ? 1 : (grid_cells > 64) ? 64 : grid_cells;
      it.tag = $urandom;
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(0, 1)) it.pos[i] = ($urandom % len) - len / 2;
         else it.pos[i] = $urandom;
         it.vel[i] = rand_speed();
      end
      if ($urandom_range(0, 9) < 7) it.cell_idx = $urandom % (n * n * n);
      else it.cell_idx = $urandom;
      // equal motion on every axis from a diagonal cell makes ties
      if ($urandom_range(0, 5) == 0) begin
         longint c;
         c = $urandom % n;
         it.cell_idx = c * n * n + c * n + c;
         for (int i = 1; i < 3; i++) begin
            it.pos[i] = it.pos[0];
            it.vel[i] = $urandom_range(0, 3) == 0 ? -it.vel[0] : it.vel[0];
         end
      end
      return it;
   endfunction

   function automatic particle_type make_particle(int tag, int px, int py, int pz,
         int vx, int vy, int vz, int cell_idx);
      particle_type it;
      it.tag = tag;
      it.pos[0] = px; it.pos[1] = py; it.pos[2] = pz;
      it.vel[0] = vx; it.vel[1] = vy; it.vel[2] = vz;
      it.cell_idx = cell_idx;
      return it;
   endfunction

   // extremes, every direction, rest, ties and oversized cell index
   task automatic test_directed();
      send_item(make_particle(0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_particle(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                              0, 0, 0, 262143));
      send_item(make_particle(1, 32'h8000, 0, 0, 32'h1_0000, 0, 0, 292));
      send_item(make_particle(2, 32'h8000, 0, 0, -32'h1_0000, 0, 0, 292));
      send_item(make_particle(3, 0, 32'h8000, 0, 0, 32'h1_0000, 0, 292));
      send_item(make_particle(4, 0, 32'h8000, 0, 0, -32'h1_0000, 0, 292));
      send_item(make_particle(5, 0, 0, 32'h8000, 0, 0, 32'h1_0000, 292));
      send_item(make_particle(6, 0, 0, 32'h8000, 0, 0, -32'h1_0000, 292));
      send_item(make_particle(7, 32'h8000, 32'h8000, 32'h8000,
                              32'h1_0000, 32'h1_0000, 32'h1_0000, 292));
      send_item(make_particle(8, 32'h8000, 32'h8000, 32'h8000,
                              -32'h1_0000, -32'h1_0000, 32'h2_0000, 292));
      send_item(make_particle(9, -32'h4_0000, -32'h4_0000, -32'h4_0000,
                              -1, -1, -1, 0));
      send_item(make_particle(10, 32'h3_FFFF, 32'h3_FFFF, 32'h3_FFFF,
                              1, 1, 1, 511));
      send_item(make_particle(11, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 511));
      send_item(make_particle(12, 32'hFFFF_FFFF, 32'h1, 32'h5555_5555,
                              32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 262143));
      send_item(make_particle(13, 0, 0, 0, 0, 32'h1_0000, 0, 512));
      send_item(make_particle(14, 0, 0, 0, 0, 0, -32'h1_0000, 131071));
   endtask

   // a run of random items under one grid setting
   task automatic test_random(int count);
      repeat (count) send_item(rand_particle());
   endtask

   task automatic test_grid_settings();
      set_grid(8, 65536, 524288);
      test_random(150);
      set_grid(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      test_random(150);
      set_grid(64, 1, 64);
      test_random(150);
      set_grid(0, 0, 0);
      test_random(150);
      set_grid(127, 4096, 262144);
      test_random(150);
      set_grid(5, 3 * 65536, 15 * 65536);
      test_random(150);
   endtask

   // steady flow with no idling on either side
   task automatic test_full_rate();
      set_grid(16, 32768, 524288);
      no_idle = 1'b1;
      test_random(150);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(40);
      test_grid_settings();
      test_full_rate();
      drain();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
